@@ hw/rtl/sbg_pkg.sv @@
// ============================================================================
// sbg_pkg
// Shared types and constants for the stereo biquad with output gain.
// ============================================================================
package sbg_pkg;

    localparam int SAMPLE_BITS         = 24;
    localparam int COEF_BITS           = 24;
    localparam int GAIN_BITS           = 24;
    localparam int CUTOFF_BITS         = 16;
    localparam int COEF_FRAC_BITS_DEF  = 20;
    localparam int QUEUE_DEPTH         = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_FB1  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_FB2  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_GAIN  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_HZ = 3'd6;

    // register reset values
    localparam logic [COEF_BITS-1:0]   RST_COEF_B0   = 24'd1048576;
    localparam logic [COEF_BITS-1:0]   RST_COEF_ZERO = 24'd0;
    localparam logic [GAIN_BITS-1:0]   RST_OUT_GAIN  = 24'd0;
    localparam logic [CUTOFF_BITS-1:0] RST_CUTOFF_HZ = 16'd22050;

    // active cutoff window
    localparam logic [CUTOFF_BITS-1:0] CUTOFF_MIN = 16'd20;
    localparam logic [CUTOFF_BITS-1:0] CUTOFF_MAX = 16'd22000;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_in;
        logic signed [SAMPLE_BITS-1:0] right_in;
        logic                          last_in_block;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
        logic                          was_filtered;
        logic                          block_active;
        logic                          end_of_block;
    } t_out;

    typedef struct packed {
        logic signed [COEF_BITS-1:0]   coef_b0;
        logic signed [COEF_BITS-1:0]   coef_b1;
        logic signed [COEF_BITS-1:0]   coef_b2;
        logic signed [COEF_BITS-1:0]   coef_fb1;
        logic signed [COEF_BITS-1:0]   coef_fb2;
        logic        [GAIN_BITS-1:0]   out_gain;
        logic        [CUTOFF_BITS-1:0] cutoff_hz;
    } t_cfg;

    // classified pair as it waits for the datapath
    typedef struct packed {
        t_in  data;
        logic filt;
        logic active;
    } t_job;

endpackage

@@ hw/rtl/stereo_biquad_with_gain_unit.sv @@
// ============================================================================
// stereo_biquad_with_gain_unit
// Stereo direct-form-1 biquad with shared coefficients and output gain,
// saturating 24-bit samples, with a write-only configuration port.
//
//   channel   direction   handshake                     payload
//   input     in          i_in_valid / o_in_stall       i_in  (t_in)
//   output    out         o_out_valid / i_out_stall     o_out (t_out)
//   config    in          i_cfg_we                      i_cfg_idx, i_cfg_data
//
// a filtered pair is popped, then one shared multiplier runs five taps plus
// the gain for each channel, then the result fills the output register
// a pass-through pair goes from the queue straight to the output register
// a two-entry queue keeps accepting pairs while the datapath works, until full
// reset is synchronous, active low; config and control registers get reset values
// a stalled output holds in its register while the datapath finishes the next pair
// ============================================================================
module stereo_biquad_with_gain_unit #(
    parameter int COEF_FRAC_BITS = sbg_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  sbg_pkg::t_in                     i_in,
    output logic                             o_in_stall,
    output logic                             o_out_valid,
    output sbg_pkg::t_out                    o_out,
    input  logic                             i_out_stall,
    input  logic                             i_cfg_we,
    input  logic [sbg_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sbg_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import sbg_pkg::*;

    t_cfg r_cfg;
    t_job w_push_job;
    t_job w_head;
    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // unity current-input tap at the chosen binary point
            r_cfg.coef_b0   <= COEF_BITS'(1) << COEF_FRAC_BITS;
            r_cfg.coef_b1   <= RST_COEF_ZERO;
            r_cfg.coef_b2   <= RST_COEF_ZERO;
            r_cfg.coef_fb1  <= RST_COEF_ZERO;
            r_cfg.coef_fb2  <= RST_COEF_ZERO;
            r_cfg.out_gain  <= RST_OUT_GAIN;
            r_cfg.cutoff_hz <= RST_CUTOFF_HZ;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_COEF_B0:   r_cfg.coef_b0   <= i_cfg_data[COEF_BITS-1:0];
                REG_COEF_B1:   r_cfg.coef_b1   <= i_cfg_data[COEF_BITS-1:0];
                REG_COEF_B2:   r_cfg.coef_b2   <= i_cfg_data[COEF_BITS-1:0];
                REG_COEF_FB1:  r_cfg.coef_fb1  <= i_cfg_data[COEF_BITS-1:0];
                REG_COEF_FB2:  r_cfg.coef_fb2  <= i_cfg_data[COEF_BITS-1:0];
                REG_OUT_GAIN:  r_cfg.out_gain  <= i_cfg_data[GAIN_BITS-1:0];
                REG_CUTOFF_HZ: r_cfg.cutoff_hz <= i_cfg_data[CUTOFF_BITS-1:0];
                default: begin
                    // unknown index, write dropped
                end
            endcase
        end
    end

    sbg_front u_front (
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .i_gain     (r_cfg.out_gain),
        .i_cutoff   (r_cfg.cutoff_hz),
        .i_q_full   (w_full),
        .o_in_stall (o_in_stall),
        .o_push     (w_push),
        .o_job      (w_push_job)
    );

    sbg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    sbg_back #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_head    (w_head),
        .i_q_empty   (w_empty),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

endmodule

@@ hw/rtl/sbg_front.sv @@
// ============================================================================
// sbg_front
// Input side: accepts sample pairs and classifies them as filtered or
// passed through, then pushes them into the job queue.
// ============================================================================
module sbg_front (
    input  logic                              i_in_valid,
    input  sbg_pkg::t_in                      i_in,
    input  logic [sbg_pkg::GAIN_BITS-1:0]     i_gain,
    input  logic [sbg_pkg::CUTOFF_BITS-1:0]   i_cutoff,
    input  logic                              i_q_full,
    output logic                              o_in_stall,
    output logic                              o_push,
    output sbg_pkg::t_job                     o_job
);
    import sbg_pkg::*;

    logic w_active;
    logic w_nonzero;

    assign w_active  = (i_cutoff >= CUTOFF_MIN) && (i_cutoff <= CUTOFF_MAX) && (i_gain != '0);
    // a zero sample in either channel skips the whole pair
    assign w_nonzero = (i_in.left_in != '0) && (i_in.right_in != '0);

    assign o_in_stall   = i_q_full;
    assign o_push       = i_in_valid && !i_q_full;
    assign o_job.data   = i_in;
    assign o_job.active = w_active;
    assign o_job.filt   = w_active && w_nonzero;

endmodule

@@ hw/rtl/sbg_queue.sv @@
// ============================================================================
// sbg_queue
// Short job queue between the input side and the filter datapath.
// ============================================================================
module sbg_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sbg_pkg::t_job  i_data,
    input  logic           i_pop,
    output sbg_pkg::t_job  o_head,
    output logic           o_full,
    output logic           o_empty
);
    import sbg_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/sbg_back.sv @@
// ============================================================================
// sbg_back
// Filter datapath: one shared registered multiplier walks the five biquad
// taps and the gain of each channel in turn, then fills the output register.
// ============================================================================
module sbg_back #(
    parameter int COEF_FRAC_BITS = sbg_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sbg_pkg::t_cfg  i_cfg,
    input  sbg_pkg::t_job  i_q_head,
    input  logic           i_q_empty,
    output logic           o_pop,
    output logic           o_out_valid,
    output sbg_pkg::t_out  o_out,
    input  logic           i_out_stall
);
    import sbg_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int PROD_W = (SB + 1) + (COEF_BITS + 1);
    localparam int ACC_W  = PROD_W + 3;

    localparam logic signed [ACC_W:0] HALF = (ACC_W + 1)'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W:0] SMAX = {{(ACC_W + 2 - SB){1'b0}}, {(SB - 1){1'b1}}};
    localparam logic signed [ACC_W:0] SMIN = ~SMAX;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MAC  = 3'd1;
    localparam logic [2:0] S_RND  = 3'd2;
    localparam logic [2:0] S_GAIN = 3'd3;
    localparam logic [2:0] S_GRND = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    localparam logic [2:0] TAP_LAST = 3'd5;

    logic [2:0]                r_state;
    logic [2:0]                r_tap;
    logic                      r_ch;
    logic                      r_out_valid;
    t_out                      r_out;
    t_job                      r_job;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [SB-1:0]      r_y;
    logic signed [SB-1:0]      r_res [2];
    logic signed [SB-1:0]      r_x1  [2];
    logic signed [SB-1:0]      r_x2  [2];
    logic signed [SB-1:0]      r_y1  [2];
    logic signed [SB-1:0]      r_y2  [2];

    logic signed [SB:0]        w_mul_a;
    logic signed [COEF_BITS:0] w_mul_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [SB-1:0]      w_x;
    logic signed [ACC_W-1:0]   w_prod_ext;
    logic signed [SB-1:0]      w_gain_res;
    logic                      w_out_free;

    // round half up at the binary point, then clamp to the sample range
    function automatic logic signed [SB-1:0] rnd_sat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W:0] t;
        logic signed [ACC_W:0] s;
        t = $signed({v[ACC_W-1], v}) + HALF;
        s = t >>> COEF_FRAC_BITS;
        if (s > SMAX) begin
            return SMAX[SB-1:0];
        end else if (s < SMIN) begin
            return SMIN[SB-1:0];
        end
        return s[SB-1:0];
    endfunction

    assign w_x        = r_ch ? r_job.data.right_in : r_job.data.left_in;
    assign w_prod     = w_mul_a * w_mul_b;
    assign w_prod_ext = {{(ACC_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign w_gain_res = rnd_sat(w_prod_ext);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_pop      = (r_state == S_IDLE) && !i_q_empty;

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        if (r_state == S_GAIN) begin
            w_mul_a = {r_y[SB-1], r_y};
            w_mul_b = {1'b0, i_cfg.out_gain};
        end else begin
            unique case (r_tap)
                3'd0: begin
                    w_mul_a = {w_x[SB-1], w_x};
                    w_mul_b = {i_cfg.coef_b0[COEF_BITS-1], i_cfg.coef_b0};
                end
                3'd1: begin
                    w_mul_a = {r_x1[r_ch][SB-1], r_x1[r_ch]};
                    w_mul_b = {i_cfg.coef_b1[COEF_BITS-1], i_cfg.coef_b1};
                end
                3'd2: begin
                    w_mul_a = {r_x2[r_ch][SB-1], r_x2[r_ch]};
                    w_mul_b = {i_cfg.coef_b2[COEF_BITS-1], i_cfg.coef_b2};
                end
                3'd3: begin
                    w_mul_a = {r_y1[r_ch][SB-1], r_y1[r_ch]};
                    w_mul_b = {i_cfg.coef_fb1[COEF_BITS-1], i_cfg.coef_fb1};
                end
                3'd4: begin
                    w_mul_a = {r_y2[r_ch][SB-1], r_y2[r_ch]};
                    w_mul_b = {i_cfg.coef_fb2[COEF_BITS-1], i_cfg.coef_fb2};
                end
                default: begin
                    w_mul_a = '0;
                    w_mul_b = '0;
                end
            endcase
        end
    end

    // control and filter history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tap       <= '0;
            r_ch        <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 2; i++) begin
                r_x1[i] <= '0;
                r_x2[i] <= '0;
                r_y1[i] <= '0;
                r_y2[i] <= '0;
            end
        end else begin
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_state <= i_q_head.filt ? S_MAC : S_DONE;
                        r_tap   <= '0;
                        r_ch    <= 1'b0;
                    end
                end
                S_MAC: begin
                    if (r_tap == TAP_LAST) begin
                        r_state <= S_RND;
                    end else begin
                        r_tap <= r_tap + 1'b1;
                    end
                end
                S_RND: begin
                    r_state <= S_GAIN;
                end
                S_GAIN: begin
                    r_state <= S_GRND;
                end
                S_GRND: begin
                    r_x1[r_ch] <= w_x;
                    r_x2[r_ch] <= r_x1[r_ch];
                    r_y1[r_ch] <= r_y;
                    r_y2[r_ch] <= r_y1[r_ch];
                    if (!r_ch) begin
                        r_ch    <= 1'b1;
                        r_tap   <= '0;
                        r_state <= S_MAC;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_q_head;
        end
        if (r_state == S_MAC) begin
            if (r_tap != TAP_LAST) begin
                r_prod <= w_prod;
            end
            // the accumulator adds the registered product of the previous tap
            if (r_tap == '0) begin
                r_acc <= '0;
            end else begin
                r_acc <= r_acc + w_prod_ext;
            end
        end
        if (r_state == S_RND) begin
            r_y <= rnd_sat(r_acc);
        end
        if (r_state == S_GAIN) begin
            r_prod <= w_prod;
        end
        if (r_state == S_GRND) begin
            r_res[r_ch] <= w_gain_res;
        end
        if ((r_state == S_DONE) && w_out_free) begin
            r_out.left_out     <= r_job.filt ? r_res[0] : r_job.data.left_in;
            r_out.right_out    <= r_job.filt ? r_res[1] : r_job.data.right_in;
            r_out.was_filtered <= r_job.filt;
            r_out.block_active <= r_job.active;
            r_out.end_of_block <= r_job.data.last_in_block;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_tap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |-> (r_tap <= TAP_LAST))
        else $error("tap counter past last tap");

    a_filt_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC || r_state == S_RND || r_state == S_GAIN || r_state == S_GRND)
        |-> r_job.filt)
        else $error("datapath running on a pass-through pair");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result presented without finishing a pair");

    a_gain_after_rnd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GAIN) |-> $past(r_state == S_RND))
        else $error("gain multiply without a rounded filter value");

endmodule

@@ tb/testbench.sv @@
// ============================================================================
// testbench
// Self-checking bench for the stereo biquad with output gain: a short set of
// directed corner pairs, then randomized coefficient settings with random
// sample streams and random backpressure on both channels. A scoreboard
// predicts every output transaction and compares it field by field.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sbg_pkg::*;

    localparam int CLK_HALF        = 6;
    localparam int FRAC            = COEF_FRAC_BITS_DEF;
    localparam int UNITY           = 1 << FRAC;
    localparam int PAIR_LATENCY    = 24;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int RANDOM_PHASES   = 12;
    localparam int PAIRS_PER_PHASE = 155;

    localparam logic [CFG_IDX_W-1:0]   REG_UNUSED = 3'd7;
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [COEF_BITS-1:0]   COEF_MAX   = {1'b0, {(COEF_BITS-1){1'b1}}};
    localparam logic [COEF_BITS-1:0]   COEF_MIN   = {1'b1, {(COEF_BITS-1){1'b0}}};
    localparam logic [GAIN_BITS-1:0]   GAIN_MAX   = {GAIN_BITS{1'b1}};

    // tracks the filter state and expected output transactions
    class biquad_scoreboard;
        logic signed [COEF_BITS-1:0] b0, b1, b2, fb1, fb2;
        logic [GAIN_BITS-1:0]        gain;
        logic [CUTOFF_BITS-1:0]      cutoff;
        longint x1[2], x2[2], y1[2], y2[2];
        t_out   expected_q[$];
        int     mismatches;
        int     results_seen;

        function void reset_state();
            b0     = RST_COEF_B0;
            b1     = RST_COEF_ZERO;
            b2     = RST_COEF_ZERO;
            fb1    = RST_COEF_ZERO;
            fb2    = RST_COEF_ZERO;
            gain   = RST_OUT_GAIN;
            cutoff = RST_CUTOFF_HZ;
            for (int c = 0; c < 2; c++) begin
                x1[c] = 0;
                x2[c] = 0;
                y1[c] = 0;
                y2[c] = 0;
            end
            expected_q.delete();
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_COEF_B0:   b0 = data;
                REG_COEF_B1:   b1 = data;
                REG_COEF_B2:   b2 = data;
                REG_COEF_FB1:  fb1 = data;
                REG_COEF_FB2:  fb2 = data;
                REG_OUT_GAIN:  gain = data;
                REG_CUTOFF_HZ: cutoff = data[CUTOFF_BITS-1:0];
                default: ;
            endcase
        endfunction

        // round half up, then clamp to the sample range
        function longint round_sat(longint v);
            longint r, hi, lo;
            hi = (longint'(1) << (SAMPLE_BITS-1)) - 1;
            lo = -hi - 1;
            r  = (v + (longint'(1) << (FRAC-1))) >>> FRAC;
            if (r > hi) return hi;
            if (r < lo) return lo;
            return r;
        endfunction

        function longint run_channel(int ch, longint x);
            longint acc, y;
            acc = longint'(b0) * x + longint'(b1) * x1[ch] + longint'(b2) * x2[ch]
                + longint'(fb1) * y1[ch] + longint'(fb2) * y2[ch];
            y      = round_sat(acc);
            y2[ch] = y1[ch];
            y1[ch] = y;
            x2[ch] = x1[ch];
            x1[ch] = x;
            return round_sat(y * longint'(gain));
        endfunction

        function void note_pair(t_in p);
            t_out e;
            logic active, filt;
            active = (cutoff >= CUTOFF_MIN) && (cutoff <= CUTOFF_MAX) && (gain != 0);
            filt   = active && (p.left_in != 0) && (p.right_in != 0);
            e.left_out  = p.left_in;
            e.right_out = p.right_in;
            if (filt) begin
                e.left_out  = SAMPLE_BITS'(run_channel(0, p.left_in));
                e.right_out = SAMPLE_BITS'(run_channel(1, p.right_in));
            end
            e.was_filtered = filt;
            e.block_active = active;
            e.end_of_block = p.last_in_block;
            expected_q.push_back(e);
        endfunction

        function void check_result(t_out got);
            t_out e;
            results_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] output transaction %0d arrived with nothing expected:",
                             $time, results_seen, " L=%0d R=%0d",
                             got.left_out, got.right_out);
                return;
            end
            e = expected_q.pop_front();
            if (got.left_out !== e.left_out || got.right_out !== e.right_out
                    || got.was_filtered !== e.was_filtered
                    || got.block_active !== e.block_active
                    || got.end_of_block !== e.end_of_block) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] mismatch on output transaction %0d: expected",
                             $time, results_seen,
                             " L=%0d R=%0d filt=%0b act=%0b eob=%0b, got",
                             e.left_out, e.right_out, e.was_filtered, e.block_active,
                             e.end_of_block,
                             " L=%0d R=%0d filt=%0b act=%0b eob=%0b",
                             got.left_out, got.right_out, got.was_filtered,
                             got.block_active, got.end_of_block);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    t_in                   i_in;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out                  o_out;
    logic                  i_out_stall;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    biquad_scoreboard sb;
    int src_idle_pct;
    int sink_idle_pct;
    int src_gap_left;
    int sink_stall_left;

    stereo_biquad_with_gain_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    function automatic t_in make_pair(logic [SAMPLE_BITS-1:0] l, logic [SAMPLE_BITS-1:0] r,
                                      logic last);
        t_in p;
        p.left_in       = l;
        p.right_in      = r;
        p.last_in_block = last;
        return p;
    endfunction

    function automatic int rand_signed(int lim);
        return int'($urandom_range(2 * lim)) - lim;
    endfunction

    function automatic int idle_level();
        case ($urandom_range(3))
            0: return 0;
            1: return 3;
            2: return 10;
            default: return 25;
        endcase
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] random_sample();
        int unsigned pick;
        logic [SAMPLE_BITS-1:0] v;
        pick = $urandom_range(99);
        if (pick < 72) begin
            v = SAMPLE_BITS'($urandom());
        end else if (pick < 92) begin
            v = SAMPLE_BITS'($urandom_range(255, 1));
            if ($urandom_range(1) == 1) v = -v;
        end else begin
            case ($urandom_range(3))
                0: v = SAMPLE_MAX;
                1: v = SAMPLE_MIN;
                2: v = SAMPLE_BITS'(1);
                default: v = SAMPLE_BITS'(-1);
            endcase
        end
        return v;
    endfunction

    function automatic t_in random_pair();
        int unsigned pick;
        logic last;
        pick = $urandom_range(99);
        last = ($urandom_range(3) == 0);
        // zero samples make the whole pair bypass the filter
        if (pick < 5) return make_pair('0, random_sample(), last);
        if (pick < 10) return make_pair(random_sample(), '0, last);
        if (pick < 12) return make_pair('0, '0, last);
        return make_pair(random_sample(), random_sample(), last);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] extreme_coef();
        case ($urandom_range(4))
            0: return COEF_MAX;
            1: return COEF_MIN;
            2: return '0;
            3: return CFG_DATA_W'(UNITY);
            default: return CFG_DATA_W'(-UNITY);
        endcase
    endfunction

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.write_reg(idx, data);
        @(posedge i_clk);
    endtask

    task automatic end_cfg();
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_pair(t_in p);
        if (src_gap_left == 0 && $urandom_range(99) < src_idle_pct)
            src_gap_left = $urandom_range(19, 1);
        while (src_gap_left > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            src_gap_left--;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in       <= p;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_pair(p);
    endtask

    task automatic wait_until_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (PAIR_LATENCY) @(posedge i_clk);
    endtask

    task automatic load_random_setting();
        int unsigned mode, pick;
        int a2, a1_lim;
        logic [CFG_DATA_W-1:0]  c[5];
        logic [GAIN_BITS-1:0]   g;
        logic [CUTOFF_BITS-1:0] hz;
        mode = $urandom_range(9);
        if (mode < 6) begin
            // stable section: |a2| < 1 and |a1| < 1 + a2
            for (int k = 0; k < 3; k++) c[k] = CFG_DATA_W'(rand_signed(UNITY));
            a2     = $urandom_range(UNITY * 8 / 10);
            a1_lim = (UNITY + a2) * 95 / 100;
            c[3]   = CFG_DATA_W'(rand_signed(a1_lim));
            c[4]   = CFG_DATA_W'(-a2);
        end else if (mode < 8) begin
            for (int k = 0; k < 5; k++) c[k] = CFG_DATA_W'($urandom());
        end else begin
            for (int k = 0; k < 5; k++) c[k] = extreme_coef();
        end
        pick = $urandom_range(9);
        case (pick)
            0, 1, 2, 3: g = GAIN_BITS'($urandom_range(UNITY * 2, UNITY / 4));
            4, 5:       g = GAIN_BITS'(UNITY);
            6:          g = GAIN_BITS'($urandom_range(GAIN_MAX, 1));
            7:          g = GAIN_MAX;
            8:          g = GAIN_BITS'($urandom_range(255, 1));
            default:    g = '0;
        endcase
        pick = $urandom_range(9);
        if (pick < 7) hz = CUTOFF_BITS'($urandom_range(CUTOFF_MAX, CUTOFF_MIN));
        else if (pick == 7) hz = $urandom_range(1) ? CUTOFF_MIN : CUTOFF_MAX;
        else if (pick == 8) hz = $urandom_range(1) ? CUTOFF_BITS'(CUTOFF_MIN - 1)
                                                   : CUTOFF_BITS'(CUTOFF_MAX + 1);
        else hz = CUTOFF_BITS'($urandom());
        write_cfg(REG_COEF_B0, c[0]);
        write_cfg(REG_COEF_B1, c[1]);
        write_cfg(REG_COEF_B2, c[2]);
        write_cfg(REG_COEF_FB1, c[3]);
        write_cfg(REG_COEF_FB2, c[4]);
        write_cfg(REG_OUT_GAIN, g);
        // upper data bits are don't-care for the cutoff register
        write_cfg(REG_CUTOFF_HZ, {8'($urandom()), hz});
        if ($urandom_range(3) == 0) write_cfg(REG_UNUSED, CFG_DATA_W'($urandom()));
        end_cfg();
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out);
    end

    initial begin : sink_backpressure
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_stall_left == 0 && $urandom_range(99) < sink_idle_pct)
                sink_stall_left = $urandom_range(19, 1);
            if (sink_stall_left > 0) begin
                i_out_stall <= 1'b1;
                sink_stall_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("testbench: errors");
        $finish;
    end

    initial begin : stimulus
        logic [CUTOFF_BITS-1:0] probe_hz[4];
        sb = new();
        sb.reset_state();
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_in            = '0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        src_gap_left    = 0;
        sink_stall_left = 0;
        src_idle_pct    = 10;
        sink_idle_pct   = 10;
        probe_hz        = '{CUTOFF_BITS'(CUTOFF_MIN - 1), CUTOFF_BITS'(CUTOFF_MAX + 1),
                            16'd0, 16'hFFFF};
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings have zero gain: everything passes through
        send_pair(make_pair(SAMPLE_MAX, SAMPLE_MIN, 1'b1));
        send_pair(make_pair(SAMPLE_MIN, SAMPLE_MAX, 1'b0));
        send_pair(make_pair(SAMPLE_BITS'(1), SAMPLE_BITS'(-1), 1'b0));
        wait_until_idle();

        // unity filter at the lowest active cutoff
        write_cfg(REG_OUT_GAIN, CFG_DATA_W'(UNITY));
        write_cfg(REG_CUTOFF_HZ, CFG_DATA_W'(CUTOFF_MIN));
        end_cfg();
        send_pair(make_pair(SAMPLE_MAX, SAMPLE_MIN, 1'b1));
        send_pair(make_pair(SAMPLE_BITS'(1), SAMPLE_BITS'(-1), 1'b0));
        send_pair(make_pair('0, SAMPLE_BITS'(5), 1'b0));
        send_pair(make_pair(SAMPLE_BITS'(7), '0, 1'b1));
        send_pair(make_pair('0, '0, 1'b0));
        send_pair(make_pair(SAMPLE_BITS'(-3), SAMPLE_BITS'(9), 1'b0));
        wait_until_idle();

        // extreme taps and gain at the highest active cutoff force saturation
        write_cfg(REG_COEF_B0, COEF_MAX);
        write_cfg(REG_COEF_B1, COEF_MIN);
        write_cfg(REG_COEF_B2, COEF_MIN);
        write_cfg(REG_COEF_FB1, COEF_MAX);
        write_cfg(REG_COEF_FB2, COEF_MIN);
        write_cfg(REG_OUT_GAIN, GAIN_MAX);
        write_cfg(REG_CUTOFF_HZ, CFG_DATA_W'(CUTOFF_MAX));
        write_cfg(REG_UNUSED, CFG_DATA_W'($urandom()));
        end_cfg();
        send_pair(make_pair(SAMPLE_MAX, SAMPLE_MIN, 1'b0));
        send_pair(make_pair(SAMPLE_MIN, SAMPLE_MAX, 1'b1));
        send_pair(make_pair(SAMPLE_BITS'(123), SAMPLE_BITS'(-456), 1'b0));
        send_pair(make_pair(SAMPLE_BITS'(1), SAMPLE_BITS'(1), 1'b0));
        wait_until_idle();

        // cutoff just outside the window on both sides and at the far ends
        for (int k = 0; k < 4; k++) begin
            write_cfg(REG_CUTOFF_HZ, CFG_DATA_W'(probe_hz[k]));
            end_cfg();
            send_pair(make_pair(random_sample(), random_sample(), k[0]));
            wait_until_idle();
        end

        // cutoff in range but zero gain
        write_cfg(REG_CUTOFF_HZ, CFG_DATA_W'(1000));
        write_cfg(REG_OUT_GAIN, '0);
        end_cfg();
        send_pair(make_pair(SAMPLE_BITS'(42), SAMPLE_BITS'(-42), 1'b1));
        wait_until_idle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            load_random_setting();
            if (ph == RANDOM_PHASES - 1) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end else begin
                src_idle_pct  = idle_level();
                sink_idle_pct = idle_level();
            end
            for (int n = 0; n < PAIRS_PER_PHASE; n++) send_pair(random_pair());
            wait_until_idle();
        end

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

@@ stereo_biquad_with_gain_unit.f @@
hw/rtl/sbg_pkg.sv
hw/rtl/sbg_front.sv
hw/rtl/sbg_queue.sv
hw/rtl/sbg_back.sv
hw/rtl/stereo_biquad_with_gain_unit.sv
tb/testbench.sv
